// ===== src/segx_pkg.sv =====
// ----------------------------------------------------------------------------
// segx_pkg
// Shared constants for the 2D segment intersection pipeline.
// ----------------------------------------------------------------------------
package segx_pkg;

    // default coordinate width, two's complement
    localparam int COORD_WIDTH_DEF = 16;

    // register stages from request to result strobe
    localparam int PIPE_DEPTH = 6;

    // bounding box slots: x of A, x of B, y of A, y of B
    localparam int NUM_BOUNDS = 4;

endpackage

// ===== src/segment_intersection_2d.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_2d
// Exact intersection test of two 2D segments, six-stage pipeline.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low. busy is
// tied low: the pipeline takes one request every cycle and never stalls.
// Each request carries the endpoints of segments A and B as signed
// COORD_WIDTH-bit coordinates.
// Once a request has passed through the pipeline, o_valid is high for one
// cycle with o_intersects and o_parallel for that request. Results come
// out in request order, one per cycle at most. The stages follow the
// multiplier chain: line terms, determinant, numerators, bound scaling.
// o_parallel flags a zero determinant (parallel, collinear or degenerate);
// o_intersects is then low. Otherwise the crossing point is checked against
// both bounding boxes, bounds included, by cross-multiplying with |det|.
// The receiver cannot hold results off, so nothing here waits on it.
// Reset clears the valid chain; requests in flight are dropped and no strobe
// follows until new requests arrive.
// ----------------------------------------------------------------------------
module segment_intersection_2d
    import segx_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_a_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_a_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_end_y,
    output logic                          o_valid,
    output logic                          o_intersects,
    output logic                          o_parallel
);

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;       // coordinate differences
    localparam int PW   = DW + CW;      // difference * coordinate
    localparam int CCW  = PW + 1;       // line constant c
    localparam int DPW  = 2 * DW;       // difference * difference
    localparam int DETW = DPW + 1;      // determinant
    localparam int NPW  = DW + CCW;     // difference * c
    localparam int NW   = NPW + 1;      // numerators
    localparam int BW   = CW + DETW;    // bound * |det|

    // valid chain
    logic [PIPE_DEPTH-1:0] r_vld;

    // stage 1: coordinates and row differences
    logic signed [CW-1:0] r1_ax0, r1_ay0, r1_ax1, r1_ay1;
    logic signed [CW-1:0] r1_bx0, r1_by0, r1_bx1, r1_by1;
    logic signed [DW-1:0] r1_a1, r1_b1, r1_a2, r1_b2;

    // stage 2: first products
    logic signed [PW-1:0]  r2_ax1p, r2_by1p, r2_ax2p, r2_by2p;
    logic signed [DPW-1:0] r2_d1, r2_d2;
    logic signed [DW-1:0]  r2_a1, r2_b1, r2_a2, r2_b2;
    logic signed [CW-1:0]  r2_lo [NUM_BOUNDS];
    logic signed [CW-1:0]  r2_hi [NUM_BOUNDS];

    // stage 3: line constants and determinant
    logic signed [CCW-1:0]  r3_c1, r3_c2;
    logic signed [DETW-1:0] r3_det;
    logic signed [DW-1:0]   r3_a1, r3_b1, r3_a2, r3_b2;
    logic signed [CW-1:0]   r3_lo [NUM_BOUNDS];
    logic signed [CW-1:0]   r3_hi [NUM_BOUNDS];

    // stage 4: numerator products, |det|
    logic signed [NPW-1:0]  r4_q1, r4_q2, r4_q3, r4_q4;
    logic signed [DETW-1:0] r4_abs;
    logic                   r4_neg, r4_zero;
    logic signed [CW-1:0]   r4_lo [NUM_BOUNDS];
    logic signed [CW-1:0]   r4_hi [NUM_BOUNDS];

    // stage 5: sign-corrected numerators, scaled bounds
    logic signed [NW-1:0] r5_nx, r5_ny;
    logic                 r5_zero;
    logic signed [BW-1:0] r5_blo [NUM_BOUNDS];
    logic signed [BW-1:0] r5_bhi [NUM_BOUNDS];

    // stage 6: result
    logic r6_hit, r6_par;

    logic signed [DETW-1:0] n_abs;
    logic [NUM_BOUNDS-1:0]  n_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], start & ~busy};
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        r1_ax0 <= i_a_start_x;
        r1_ay0 <= i_a_start_y;
        r1_ax1 <= i_a_end_x;
        r1_ay1 <= i_a_end_y;
        r1_bx0 <= i_b_start_x;
        r1_by0 <= i_b_start_y;
        r1_bx1 <= i_b_end_x;
        r1_by1 <= i_b_end_y;
        r1_a1  <= DW'(i_a_end_y) - DW'(i_a_start_y);
        r1_b1  <= DW'(i_a_start_x) - DW'(i_a_end_x);
        r1_a2  <= DW'(i_b_end_y) - DW'(i_b_start_y);
        r1_b2  <= DW'(i_b_start_x) - DW'(i_b_end_x);
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        r2_ax1p <= PW'(r1_a1) * PW'(r1_ax0);
        r2_by1p <= PW'(r1_b1) * PW'(r1_ay0);
        r2_ax2p <= PW'(r1_a2) * PW'(r1_bx0);
        r2_by2p <= PW'(r1_b2) * PW'(r1_by0);
        r2_d1   <= DPW'(r1_a1) * DPW'(r1_b2);
        r2_d2   <= DPW'(r1_a2) * DPW'(r1_b1);
        r2_a1   <= r1_a1;
        r2_b1   <= r1_b1;
        r2_a2   <= r1_a2;
        r2_b2   <= r1_b2;
        r2_lo[0] <= (r1_ax0 < r1_ax1) ? r1_ax0 : r1_ax1;
        r2_hi[0] <= (r1_ax0 > r1_ax1) ? r1_ax0 : r1_ax1;
        r2_lo[1] <= (r1_bx0 < r1_bx1) ? r1_bx0 : r1_bx1;
        r2_hi[1] <= (r1_bx0 > r1_bx1) ? r1_bx0 : r1_bx1;
        r2_lo[2] <= (r1_ay0 < r1_ay1) ? r1_ay0 : r1_ay1;
        r2_hi[2] <= (r1_ay0 > r1_ay1) ? r1_ay0 : r1_ay1;
        r2_lo[3] <= (r1_by0 < r1_by1) ? r1_by0 : r1_by1;
        r2_hi[3] <= (r1_by0 > r1_by1) ? r1_by0 : r1_by1;
    end

    // stage 3
    always_ff @(posedge i_clk) begin
        r3_c1  <= CCW'(r2_ax1p) + CCW'(r2_by1p);
        r3_c2  <= CCW'(r2_ax2p) + CCW'(r2_by2p);
        r3_det <= DETW'(r2_d1) - DETW'(r2_d2);
        r3_a1  <= r2_a1;
        r3_b1  <= r2_b1;
        r3_a2  <= r2_a2;
        r3_b2  <= r2_b2;
        r3_lo  <= r2_lo;
        r3_hi  <= r2_hi;
    end

    assign n_abs = r3_det[DETW-1] ? -r3_det : r3_det;

    // stage 4
    always_ff @(posedge i_clk) begin
        r4_q1   <= NPW'(r3_b2) * NPW'(r3_c1);
        r4_q2   <= NPW'(r3_b1) * NPW'(r3_c2);
        r4_q3   <= NPW'(r3_a1) * NPW'(r3_c2);
        r4_q4   <= NPW'(r3_a2) * NPW'(r3_c1);
        r4_abs  <= n_abs;
        r4_neg  <= r3_det[DETW-1];
        r4_zero <= (r3_det == '0);
        r4_lo   <= r3_lo;
        r4_hi   <= r3_hi;
    end

    // stage 5: negative det swaps the subtraction instead of negating after
    always_ff @(posedge i_clk) begin
        r5_nx   <= r4_neg ? NW'(r4_q2) - NW'(r4_q1) : NW'(r4_q1) - NW'(r4_q2);
        r5_ny   <= r4_neg ? NW'(r4_q4) - NW'(r4_q3) : NW'(r4_q3) - NW'(r4_q4);
        r5_zero <= r4_zero;
        for (int i = 0; i < NUM_BOUNDS; i++) begin
            r5_blo[i] <= BW'(r4_lo[i]) * BW'(r4_abs);
            r5_bhi[i] <= BW'(r4_hi[i]) * BW'(r4_abs);
        end
    end

    // x bounds in slots 0 and 1, y bounds in 2 and 3
    always_comb begin
        for (int i = 0; i < NUM_BOUNDS; i++) begin
            if (i < 2) begin
                n_in[i] = (r5_nx >= NW'(r5_blo[i])) && (r5_nx <= NW'(r5_bhi[i]));
            end else begin
                n_in[i] = (r5_ny >= NW'(r5_blo[i])) && (r5_ny <= NW'(r5_bhi[i]));
            end
        end
    end

    // stage 6
    always_ff @(posedge i_clk) begin
        r6_hit <= ~r5_zero & (&n_in);
        r6_par <= r5_zero;
    end

    assign busy         = 1'b0;
    assign o_valid      = r_vld[PIPE_DEPTH-1];
    assign o_intersects = r6_hit;
    assign o_parallel   = r6_par;

endmodule

// ===== test/tb_segment_intersection_2d.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_intersection_2d
// Self-checking bench for the 2D segment intersection pipeline.
// ----------------------------------------------------------------------------
// Segment pairs are queued by an initial block and sent by a driver at the
// falling edge, with random gaps and runs without gaps. At every accepted
// request the expected flags are computed exactly in 64-bit integers and
// queued. A monitor at the rising edge compares each result strobe with the
// oldest queued expectation. Directed cases come first (parallel, collinear,
// degenerate, touching, near misses, extremes), then random pairs of several
// shapes.
// ----------------------------------------------------------------------------
module tb_segment_intersection_2d;
    import segx_pkg::*;

    localparam int          CW          = COORD_WIDTH_DEF;
    localparam int          RAND_ITEMS  = 450;
    localparam int          MAX_REPORTS = 10;
    localparam longint      TIMEOUT_NS  = 2_000_000;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct {
        t_coord ax0, ay0, ax1, ay1;
        t_coord bx0, by0, bx1, by1;
        bit     wait_drain;     // hold the request until nothing is outstanding
    } t_seg_req;

    typedef struct {
        logic intersects;
        logic parallel;
    } t_seg_flags;

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start   = 1'b0;
    logic   busy;
    t_coord i_a_start_x = '0;
    t_coord i_a_start_y = '0;
    t_coord i_a_end_x   = '0;
    t_coord i_a_end_y   = '0;
    t_coord i_b_start_x = '0;
    t_coord i_b_start_y = '0;
    t_coord i_b_end_x   = '0;
    t_coord i_b_end_y   = '0;
    logic   o_valid;
    logic   o_intersects;
    logic   o_parallel;

    t_seg_req    pend_q[$];
    t_seg_flags  flags_q[$];
    t_seg_req    cur_req;
    t_seg_flags  want;
    logic        taken    = 1'b0;
    int unsigned gap_left = 0;
    bit          no_idle  = 1'b0;
    int          err_count  = 0;
    int          n_queued   = 0;
    int          n_accepted = 0;

    segment_intersection_2d #(
        .COORD_WIDTH (CW)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_a_start_x  (i_a_start_x),
        .i_a_start_y  (i_a_start_y),
        .i_a_end_x    (i_a_end_x),
        .i_a_end_y    (i_a_end_y),
        .i_b_start_x  (i_b_start_x),
        .i_b_start_y  (i_b_start_y),
        .i_b_end_x    (i_b_end_x),
        .i_b_end_y    (i_b_end_y),
        .o_valid      (o_valid),
        .o_intersects (o_intersects),
        .o_parallel   (o_parallel)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // num/den within [min(p,q), max(p,q)], den positive
    function automatic bit in_span(longint num, longint den, longint p, longint q);
        longint lo_b, hi_b;
        lo_b = (p < q) ? p : q;
        hi_b = (p > q) ? p : q;
        return (num >= lo_b * den) && (num <= hi_b * den);
    endfunction

    function automatic t_seg_flags predict_crossing(t_seg_req r);
        longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        longint la, lb, lc, ma, mb, mc, det, nx, ny;
        t_seg_flags res;
        ax0 = r.ax0; ay0 = r.ay0; ax1 = r.ax1; ay1 = r.ay1;
        bx0 = r.bx0; by0 = r.by0; bx1 = r.bx1; by1 = r.by1;
        la  = ay1 - ay0;
        lb  = ax0 - ax1;
        lc  = la * ax0 + lb * ay0;
        ma  = by1 - by0;
        mb  = bx0 - bx1;
        mc  = ma * bx0 + mb * by0;
        det = la * mb - ma * lb;
        res.parallel   = (det == 0);
        res.intersects = 1'b0;
        if (det != 0) begin
            nx = mb * lc - lb * mc;
            ny = la * mc - ma * lc;
            if (det < 0) begin
                det = -det;
                nx  = -nx;
                ny  = -ny;
            end
            res.intersects = in_span(nx, det, ax0, ax1) && in_span(nx, det, bx0, bx1) &&
                             in_span(ny, det, ay0, ay1) && in_span(ny, det, by0, by1);
        end
        return res;
    endfunction

    task automatic add_pair(input int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1,
                            input bit drain);
        t_seg_req r;
        r.ax0 = CW'(ax0); r.ay0 = CW'(ay0); r.ax1 = CW'(ax1); r.ay1 = CW'(ay1);
        r.bx0 = CW'(bx0); r.by0 = CW'(by0); r.bx1 = CW'(bx1); r.by1 = CW'(by1);
        r.wait_drain = drain;
        pend_q.push_back(r);
    endtask

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic int pick_corner();
        case ($urandom_range(0, 6))
            0: return -(1 << (CW - 1));
            1: return (1 << (CW - 1)) - 1;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return int'($urandom_range(0, (1 << CW) - 1));
        endcase
    endfunction

    // driver: requests change at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !taken) begin
            // request not yet taken, hold it
        end else if (gap_left != 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pend_q.size() != 0 &&
                     !(pend_q[0].wait_drain && flags_q.size() != 0)) begin
            cur_req      = pend_q.pop_front();
            i_a_start_x <= cur_req.ax0;
            i_a_start_y <= cur_req.ay0;
            i_a_end_x   <= cur_req.ax1;
            i_a_end_y   <= cur_req.ay1;
            i_b_start_x <= cur_req.bx0;
            i_b_start_y <= cur_req.by0;
            i_b_end_x   <= cur_req.bx1;
            i_b_end_y   <= cur_req.by1;
            start       <= 1'b1;
            if ($urandom_range(0, 39) == 0)
                no_idle = !no_idle;
            gap_left <= pick_gap();
        end else begin
            start <= 1'b0;
        end
    end

    // monitor: results checked, requests recorded at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid !== 1'b0 && o_valid !== 1'b1) begin
                note_error("o_valid unknown");
            end else if (o_valid) begin
                if (flags_q.size() == 0) begin
                    note_error($sformatf("unexpected result: intersects=%b parallel=%b",
                                         o_intersects, o_parallel));
                end else begin
                    want = flags_q.pop_front();
                    if (o_intersects !== want.intersects)
                        note_error($sformatf("intersects: expected %b, got %b",
                                             want.intersects, o_intersects));
                    if (o_parallel !== want.parallel)
                        note_error($sformatf("parallel: expected %b, got %b",
                                             want.parallel, o_parallel));
                end
            end
            if (start && busy === 1'b0) begin
                flags_q.push_back(predict_crossing(cur_req));
                n_accepted++;
            end
        end
        taken <= i_rst_n && start && (busy === 1'b0);
    end

    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int  c[8];
        int  kind, dx, dy, px, py, qx, qy, k1, k2, m1, m2, cx, cy;
        bit  drain;

        // directed
        add_pair(0, 0, 10, 10, 0, 10, 10, 0, 0);            // plain crossing
        add_pair(0, 10, 10, 0, 0, 0, 10, 10, 0);            // same pair swapped, positive determinant
        add_pair(0, 0, 10, 0, 0, 5, 10, 5, 0);              // parallel
        add_pair(0, 0, 10, 10, 5, 5, 15, 15, 0);            // collinear, overlapping
        add_pair(3, 3, 3, 3, 0, 0, 7, 9, 0);                // A is a point
        add_pair(-4, 2, 8, 1, 5, 5, 5, 5, 0);               // B is a point
        add_pair(2, 2, 2, 2, 2, 2, 2, 2, 0);                // both points
        add_pair(0, 0, 1, 1, 10, 0, 9, 1, 0);               // lines cross off both boxes
        add_pair(0, 0, 10, 10, 10, 10, 20, 0, 0);           // shared endpoint
        add_pair(0, 0, 10, 0, 5, 0, 5, 10, 0);              // T touch
        add_pair(0, 0, 10, 10, 11, 9, 20, 0, 0);            // just off B
        add_pair(0, 0, 0, 10, 1, 5, 10, 5, 0);              // just off B, on A
        add_pair(0, 0, 1, 1, 0, 1, 1, 0, 0);                // crossing at half steps
        add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 1);
        add_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767, 0);
        add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 0);
        add_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0);
        add_pair(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768, 0);
        add_pair(21845, -21846, -21846, 21845, -21846, -21846, 21845, 21845, 0);
        add_pair(-32768, -32768, 32767, -32767, -32768, -32767, 32767, -32768, 0);
        add_pair(32767, 0, 32766, 0, 32767, 1, 32767, -1, 0);

        for (int i = 0; i < RAND_ITEMS; i++) begin
            kind  = $urandom_range(0, 99);
            drain = (i == 0) || ($urandom_range(0, 79) == 0);
            if (kind < 35) begin
                foreach (c[j]) c[j] = int'($urandom_range(0, (1 << CW) - 1));
            end else if (kind < 60) begin
                // tiny grid: many touches, parallels and points
                foreach (c[j]) c[j] = int'($urandom_range(0, 16)) - 8;
            end else if (kind < 75) begin
                // both segments around one spot, so crossings are common
                cx = int'($urandom_range(0, 64000)) - 32000;
                cy = int'($urandom_range(0, 64000)) - 32000;
                for (int j = 0; j < 4; j++) begin
                    c[2*j]   = cx + int'($urandom_range(0, 1024)) - 512;
                    c[2*j+1] = cy + int'($urandom_range(0, 1024)) - 512;
                end
            end else if (kind < 87) begin
                // same direction, collinear about half the time
                dx = int'($urandom_range(0, 40)) - 20;
                dy = int'($urandom_range(0, 40)) - 20;
                px = int'($urandom_range(0, 400)) - 200;
                py = int'($urandom_range(0, 400)) - 200;
                k1 = int'($urandom_range(0, 10)) - 5;
                k2 = int'($urandom_range(0, 10)) - 5;
                m1 = int'($urandom_range(0, 10)) - 5;
                m2 = int'($urandom_range(0, 10)) - 5;
                if ($urandom_range(0, 1)) begin
                    qx = px;
                    qy = py;
                end else begin
                    qx = int'($urandom_range(0, 400)) - 200;
                    qy = int'($urandom_range(0, 400)) - 200;
                end
                c[0] = px + k1 * dx; c[1] = py + k1 * dy;
                c[2] = px + k2 * dx; c[3] = py + k2 * dy;
                c[4] = qx + m1 * dx; c[5] = qy + m1 * dy;
                c[6] = qx + m2 * dx; c[7] = qy + m2 * dy;
            end else begin
                foreach (c[j]) c[j] = pick_corner();
                if ($urandom_range(0, 1)) begin
                    c[4] = c[2];
                    c[5] = c[3];
                end
            end
            add_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], drain);
        end
        n_queued = pend_q.size();

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted != n_queued) @(posedge i_clk);
        while (flags_q.size() != 0) @(posedge i_clk);
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);

        if (err_count == 0 && flags_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
